// ===== src/refcounted_format_type_table_macros.svh =====
// Assertion macros used by the checker file of the texture type table.
`ifndef REFCOUNTED_FORMAT_TYPE_TABLE_MACROS_SVH
`define REFCOUNTED_FORMAT_TYPE_TABLE_MACROS_SVH

// Clocked assertion that is ignored while reset is high.
`define RCFTT_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Clocked assertion that also holds while reset is high.
`define RCFTT_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== src/rcftt_pkg.sv =====
// Types, codes and helper functions of the reference-counted texture type table.
package rcftt_pkg;

   // Default table depth and largest side with a valid size class.
   localparam int ENTRIES_DEF  = 128;
   localparam int MAX_SIDE_DEF = 256;

   // Saturation limit of a reference count.
   localparam logic [15:0] COUNT_MAX = 16'hFFFF;

   // Request kinds.
   localparam logic KIND_ACQUIRE = 1'b0;
   localparam logic KIND_RELEASE = 1'b1;

   // Result status codes.
   localparam logic [2:0] ST_FOUND      = 3'd0;
   localparam logic [2:0] ST_INSERTED   = 3'd1;
   localparam logic [2:0] ST_FULL       = 3'd2;
   localparam logic [2:0] ST_STILL_USED = 3'd3;
   localparam logic [2:0] ST_NOW_FREE   = 3'd4;
   localparam logic [2:0] ST_FREE_REL   = 3'd5;
   localparam logic [2:0] ST_SATURATED  = 3'd6;

   // One request transaction.
   typedef struct packed {
      logic        kind;
      logic [11:0] width;
      logic [11:0] height;
      logic [3:0]  mip_levels;
      logic [2:0]  stage;
      logic [31:0] format_tag;
      logic [6:0]  entry_index;
   } req_type;

   // One result transaction.
   typedef struct packed {
      logic [2:0]  status;
      logic [6:0]  entry_out;
      logic [15:0] ref_count_out;
      logic [3:0]  size_class;
      logic        size_valid;
   } rsp_type;

   // Lookup key of a texture type.
   typedef struct packed {
      logic [11:0] width;
      logic [11:0] height;
      logic [3:0]  mip_levels;
      logic [2:0]  stage;
      logic [31:0] format_tag;
   } key_type;

   // One table row: key, size class with valid flag on top, and count.
   typedef struct packed {
      key_type     key;
      logic [4:0]  cls;
      logic [15:0] count;
   } row_type;

   // Size class of a texture: valid flag on bit 4, log2 of the larger side
   // rounded up to a power of two in bits 3..0.
   function automatic logic [4:0] class_of(input logic [11:0] w,
                                           input logic [11:0] h,
                                           input int          max_side);
      logic [11:0] side;
      logic [3:0]  c;
      logic        found;
      side  = (w > h) ? w : h;
      c     = '0;
      found = 1'b0;
      for (int i = 0; i < 13; i++) begin
         if (!found && ((13'd1 << i) >= {1'b0, side})) begin
            c     = 4'(i);
            found = 1'b1;
         end
      end
      if (side == 12'd0 || 32'(side) > 32'(max_side)) begin
         return 5'd0;
      end
      return {1'b1, c};
   endfunction

endpackage

// ===== src/refcounted_format_type_table.sv =====
// Top level of the reference-counted texture type table.
//
// Requests enter on req_item when start is high and busy is low. An acquire
// looks up the key (width, height, mip levels, stage, format tag) among live
// entries and raises the count of the first match unless it is saturated,
// else claims the lowest free entry or reports a full table; a release
// lowers the count of the entry it names if it is live. Exactly one result
// per request appears on rsp_item, qualified by strobe for a single cycle.
// The receiver cannot stall, so results are never held. An acquire walks the
// table through the single read port of the row memory and one shared key
// comparator, one entry per cycle, and stops at the first match; a finish
// state registers the result and writes any new count. A release reads the
// named row, then registers the result and writes back any lowered count.
// busy is high until the result is shown and drops in the strobe cycle, so
// one request is in flight at a time. After reset the block sweeps the row
// memory and zeroes every count, one entry per cycle; busy stays high during
// that pass. Key and size class of an entry are meaningful only while live.
module refcounted_format_type_table
   import rcftt_pkg::*;
#(
   parameter int ENTRIES  = ENTRIES_DEF,
   parameter int MAX_SIDE = MAX_SIDE_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    strobe,
   output rsp_type rsp_item
);

   localparam int IDX_W = $clog2(ENTRIES);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

   // Sequencer states.
   localparam logic [2:0] S_CLEAR   = 3'd0;
   localparam logic [2:0] S_IDLE    = 3'd1;
   localparam logic [2:0] S_SCAN    = 3'd2;
   localparam logic [2:0] S_FINISH  = 3'd3;
   localparam logic [2:0] S_REL_RD  = 3'd4;
   localparam logic [2:0] S_REL_CHK = 3'd5;

   // Row memory.
   row_type mem [ENTRIES];

   logic [2:0]       state_ff, state_in;
   req_type          req_ff, req_in;
   logic [4:0]       cls_ff, cls_in;
   logic [IDX_W-1:0] scan_ff, scan_in;
   logic             issue_done_ff, issue_done_in;
   logic             chk_v_ff, chk_v_in;
   logic [IDX_W-1:0] chk_idx_ff, chk_idx_in;
   row_type          row_ff;
   logic             hit_ff, hit_in;
   logic [IDX_W-1:0] tgt_idx_ff, tgt_idx_in;
   logic [15:0]      tgt_cnt_ff, tgt_cnt_in;
   logic             free_v_ff, free_v_in;
   logic [IDX_W-1:0] free_idx_ff, free_idx_in;
   logic             strobe_ff, strobe_in;
   rsp_type          rsp_ff, rsp_in;

   logic             rd_en;
   logic [IDX_W-1:0] rd_addr;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   row_type          wr_row;

   key_type          req_key;
   logic [IDX_W-1:0] rel_addr;
   logic             idx_ok;
   logic             row_live;
   logic             key_match;
   logic [15:0]      rel_cnt;

   // Request key and release address decode.
   assign req_key  = '{width: req_ff.width, height: req_ff.height,
                       mip_levels: req_ff.mip_levels, stage: req_ff.stage,
                       format_tag: req_ff.format_tag};
   assign rel_addr = IDX_W'(req_ff.entry_index);
   assign idx_ok   = (32'(req_ff.entry_index) < 32'(ENTRIES));

   // Shared comparator on the row just read.
   assign row_live  = (row_ff.count != 16'd0);
   assign key_match = row_live && (row_ff.key == req_key);
   assign rel_cnt   = row_ff.count - 16'd1;

   // Sequencer and memory control.
   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      cls_in        = cls_ff;
      scan_in       = scan_ff;
      issue_done_in = issue_done_ff;
      chk_v_in      = 1'b0;
      chk_idx_in    = chk_idx_ff;
      hit_in        = hit_ff;
      tgt_idx_in    = tgt_idx_ff;
      tgt_cnt_in    = tgt_cnt_ff;
      free_v_in     = free_v_ff;
      free_idx_in   = free_idx_ff;
      strobe_in     = 1'b0;
      rsp_in        = rsp_ff;
      rd_en         = 1'b0;
      rd_addr       = scan_ff;
      wr_en         = 1'b0;
      wr_addr       = scan_ff;
      wr_row        = '0;

      case (state_ff)
         S_CLEAR: begin
            wr_en = 1'b1;
            if (scan_ff == LAST_IDX) begin
               state_in = S_IDLE;
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         end

         S_IDLE: begin
            if (start) begin
               req_in        = req_item;
               cls_in        = class_of(req_item.width, req_item.height, MAX_SIDE);
               scan_in       = '0;
               issue_done_in = 1'b0;
               hit_in        = 1'b0;
               free_v_in     = 1'b0;
               state_in      = (req_item.kind == KIND_RELEASE) ? S_REL_RD : S_SCAN;
            end
         end

         S_SCAN: begin
            // Issue one read per cycle until the last entry is requested.
            if (!issue_done_ff) begin
               rd_en      = 1'b1;
               chk_v_in   = 1'b1;
               chk_idx_in = scan_ff;
               if (scan_ff == LAST_IDX) begin
                  issue_done_in = 1'b1;
               end else begin
                  scan_in = scan_ff + 1'b1;
               end
            end
            // Check the row read in the previous cycle.
            if (chk_v_ff) begin
               if (key_match) begin
                  hit_in     = 1'b1;
                  tgt_idx_in = chk_idx_ff;
                  tgt_cnt_in = row_ff.count;
                  state_in   = S_FINISH;
               end else begin
                  if (!row_live && !free_v_ff) begin
                     free_v_in   = 1'b1;
                     free_idx_in = chk_idx_ff;
                  end
                  if (chk_idx_ff == LAST_IDX) begin
                     state_in = S_FINISH;
                  end
               end
            end
         end

         S_FINISH: begin
            strobe_in         = 1'b1;
            state_in          = S_IDLE;
            rsp_in.size_class = cls_ff[3:0];
            rsp_in.size_valid = cls_ff[4];
            wr_row.key        = req_key;
            wr_row.cls        = cls_ff;
            if (hit_ff) begin
               rsp_in.entry_out = 7'(tgt_idx_ff);
               wr_addr          = tgt_idx_ff;
               if (tgt_cnt_ff == COUNT_MAX) begin
                  rsp_in.status        = ST_SATURATED;
                  rsp_in.ref_count_out = COUNT_MAX;
               end else begin
                  wr_en                = 1'b1;
                  wr_row.count         = tgt_cnt_ff + 16'd1;
                  rsp_in.status        = ST_FOUND;
                  rsp_in.ref_count_out = tgt_cnt_ff + 16'd1;
               end
            end else if (free_v_ff) begin
               wr_en                = 1'b1;
               wr_addr              = free_idx_ff;
               wr_row.count         = 16'd1;
               rsp_in.status        = ST_INSERTED;
               rsp_in.entry_out     = 7'(free_idx_ff);
               rsp_in.ref_count_out = 16'd1;
            end else begin
               rsp_in.status        = ST_FULL;
               rsp_in.entry_out     = 7'd0;
               rsp_in.ref_count_out = 16'd0;
            end
         end

         S_REL_RD: begin
            rd_en    = idx_ok;
            rd_addr  = rel_addr;
            state_in = S_REL_CHK;
         end

         S_REL_CHK: begin
            strobe_in        = 1'b1;
            state_in         = S_IDLE;
            rsp_in.entry_out = req_ff.entry_index;
            if (!idx_ok || !row_live) begin
               rsp_in.status        = ST_FREE_REL;
               rsp_in.ref_count_out = 16'd0;
               rsp_in.size_class    = 4'd0;
               rsp_in.size_valid    = 1'b0;
            end else begin
               wr_en                = 1'b1;
               wr_addr              = rel_addr;
               wr_row.key           = row_ff.key;
               wr_row.cls           = row_ff.cls;
               wr_row.count         = rel_cnt;
               rsp_in.status        = (rel_cnt == 16'd0) ? ST_NOW_FREE : ST_STILL_USED;
               rsp_in.ref_count_out = rel_cnt;
               rsp_in.size_class    = row_ff.cls[3:0];
               rsp_in.size_valid    = row_ff.cls[4];
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         scan_ff       <= '0;
         issue_done_ff <= 1'b0;
         chk_v_ff      <= 1'b0;
         hit_ff        <= 1'b0;
         free_v_ff     <= 1'b0;
         strobe_ff     <= 1'b0;
      end else begin
         state_ff      <= state_in;
         scan_ff       <= scan_in;
         issue_done_ff <= issue_done_in;
         chk_v_ff      <= chk_v_in;
         hit_ff        <= hit_in;
         free_v_ff     <= free_v_in;
         strobe_ff     <= strobe_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      cls_ff      <= cls_in;
      chk_idx_ff  <= chk_idx_in;
      tgt_idx_ff  <= tgt_idx_in;
      tgt_cnt_ff  <= tgt_cnt_in;
      free_idx_ff <= free_idx_in;
      rsp_ff      <= rsp_in;
   end

   // Row memory read port with registered data.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         row_ff <= mem[rd_addr];
      end
   end

   // Row memory write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_row;
      end
   end

   assign busy     = (state_ff != S_IDLE);
   assign strobe   = strobe_ff;
   assign rsp_item = rsp_ff;

endmodule

// ===== src/rcftt_checker.sv =====
// Port-level checker of the texture type table and its bind statement.
`include "refcounted_format_type_table_macros.svh"

module rcftt_checker
   import rcftt_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input logic    strobe,
   input rsp_type rsp_item
);

   // An accepted transaction keeps the block busy in the next cycle.
   `RCFTT_ASSERT(a_accept_busy, (start && !busy) |=> busy, "accept not followed by busy")

   // A result is only shown once the block has finished its work.
   `RCFTT_ASSERT(a_strobe_idle, strobe |-> !busy, "result shown while busy")

   // A new entry always starts with a count of one.
   `RCFTT_ASSERT(a_insert_one, (strobe && rsp_item.status == ST_INSERTED) |-> (rsp_item.ref_count_out == 16'd1), "insert count is not one")

   // A full table reports entry zero and a zero count.
   `RCFTT_ASSERT(a_full_zero, (strobe && rsp_item.status == ST_FULL) |-> (rsp_item.entry_out == 7'd0 && rsp_item.ref_count_out == 16'd0), "table full result not zero")

   // No result is shown in the cycle after reset.
   `RCFTT_ASSERT_ALWAYS(a_reset_quiet, reset |=> !strobe, "result right after reset")

endmodule

bind refcounted_format_type_table rcftt_checker u_rcftt_checker (.*);

// ===== sim/refcounted_format_type_table_test.sv =====
// Self-checking testbench for the reference-counted texture type table.
module refcounted_format_type_table_test
   import rcftt_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH        = ENTRIES_DEF;
   localparam int SIDE_LIMIT   = MAX_SIDE_DEF;
   localparam int RANDOM_ITEMS = 550;
   localparam int POOL_SIZE    = 20;
   localparam int QUIET_LIMIT  = 4000;
   localparam int TABLE_ROWS   = 23;

   // Size class with its valid flag, as the table stores it per entry.
   typedef struct packed {
      logic [3:0] cls;
      logic       ok;
   } size_info_type;

   // One row of the directed stimulus: the request and, where pinned, its result.
   typedef struct packed {
      req_type req;
      logic    pinned;
      rsp_type rsp;
   } stim_row_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_item = '0;
   logic    strobe;
   rsp_type rsp_item;

   // Shadow copy of the table contents.
   logic [15:0]   live_count [DEPTH] = '{default: '0};
   key_type       held_key   [DEPTH];
   size_info_type held_size  [DEPTH];

   rsp_type pending_results [$];
   logic    idling_on = 1'b1;
   int      quiet_cycles = 0;
   int      error_count = 0;
   int      requests_sent = 0;
   int      results_checked = 0;
   int      status_seen [8] = '{default: 0};

   refcounted_format_type_table #(
      .ENTRIES  (DEPTH),
      .MAX_SIDE (SIDE_LIMIT)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_item (req_item),
      .strobe   (strobe),
      .rsp_item (rsp_item)
   );

   // 100 MHz clock.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Log2 of the larger side after rounding up to a power of two.
   function automatic size_info_type size_class_of(logic [11:0] w, logic [11:0] h);
      size_info_type si;
      logic [11:0]   side;
      int            c;
      side = (w > h) ? w : h;
      c = 0;
      while ((1 << c) < side) begin
         c++;
      end
      si.ok  = (side != 0) && (side <= SIDE_LIMIT);
      si.cls = si.ok ? 4'(c) : 4'd0;
      return si;
   endfunction

   // Applies one request to the shadow table and returns the result it gives.
   function automatic rsp_type table_outcome(req_type r);
      key_type       k;
      size_info_type si;
      rsp_type       o;
      int            slot;
      o = '0;
      slot = -1;
      if (r.kind == KIND_ACQUIRE) begin
         k = '{r.width, r.height, r.mip_levels, r.stage, r.format_tag};
         si = size_class_of(r.width, r.height);
         o.size_class = si.cls;
         o.size_valid = si.ok;
         // Lowest live entry with the same key wins.
         for (int i = 0; i < DEPTH; i++) begin
            if (slot < 0 && live_count[i] != 0 && held_key[i] == k) begin
               slot = i;
            end
         end
         if (slot >= 0) begin
            if (live_count[slot] == COUNT_MAX) begin
               o.status = ST_SATURATED;
            end else begin
               live_count[slot]++;
               o.status = ST_FOUND;
            end
            o.entry_out     = 7'(slot);
            o.ref_count_out = live_count[slot];
         end else begin
            // No hit: claim the lowest free entry if there is one.
            for (int i = 0; i < DEPTH; i++) begin
               if (slot < 0 && live_count[i] == 0) begin
                  slot = i;
               end
            end
            if (slot >= 0) begin
               held_key[slot]   = k;
               held_size[slot]  = si;
               live_count[slot] = 16'd1;
               o.status         = ST_INSERTED;
               o.entry_out      = 7'(slot);
               o.ref_count_out  = 16'd1;
            end else begin
               o.status = ST_FULL;
            end
         end
      end else begin
         slot = int'(r.entry_index);
         o.entry_out = r.entry_index;
         if (slot >= DEPTH || live_count[slot] == 0) begin
            o.status = ST_FREE_REL;
         end else begin
            live_count[slot]--;
            o.status        = (live_count[slot] == 0) ? ST_NOW_FREE : ST_STILL_USED;
            o.ref_count_out = live_count[slot];
            o.size_class    = held_size[slot].cls;
            o.size_valid    = held_size[slot].ok;
         end
      end
      return o;
   endfunction

   function automatic key_type key_of(int w, int h, int m, int s, logic [31:0] f);
      key_type k;
      k.width      = 12'(w);
      k.height     = 12'(h);
      k.mip_levels = 4'(m);
      k.stage      = 3'(s);
      k.format_tag = f;
      return k;
   endfunction

   // Any key the fields allow, sizes mostly out of range.
   function automatic key_type fresh_key();
      return key_of($urandom_range(4095), $urandom_range(4095), $urandom_range(15),
                    $urandom_range(7), $urandom());
   endfunction

   // Acquire carries a random entry index that the block must ignore.
   function automatic req_type acquire_req(key_type k);
      req_type r;
      r.kind        = KIND_ACQUIRE;
      r.width       = k.width;
      r.height      = k.height;
      r.mip_levels  = k.mip_levels;
      r.stage       = k.stage;
      r.format_tag  = k.format_tag;
      r.entry_index = 7'($urandom());
      return r;
   endfunction

   // Release carries random key fields that the block must ignore.
   function automatic req_type release_req(int idx);
      req_type r;
      r.kind        = KIND_RELEASE;
      r.width       = 12'($urandom());
      r.height      = 12'($urandom());
      r.mip_levels  = 4'($urandom());
      r.stage       = 3'($urandom());
      r.format_tag  = $urandom();
      r.entry_index = 7'(idx);
      return r;
   endfunction

   function automatic rsp_type result_of(logic [2:0] st, int ent, int cnt, int cls,
                                         logic ok);
      rsp_type o;
      o.status        = st;
      o.entry_out     = 7'(ent);
      o.ref_count_out = 16'(cnt);
      o.size_class    = 4'(cls);
      o.size_valid    = ok;
      return o;
   endfunction

   function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
         error_count++;
      end
   endfunction

   // Drives one request transaction, waits for it to be taken and records
   // the result it must produce. start stays high for a following request.
   task automatic apply_request(input req_type r, input logic pinned,
                                input rsp_type known_rsp);
      rsp_type predicted;
      if (idling_on && $urandom_range(99) < 12) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_item <= r;
      start    <= 1'b1;
      do @(posedge clock); while (busy !== 1'b0);
      predicted = table_outcome(r);
      pending_results.push_back(pinned ? known_rsp : predicted);
      requests_sent++;
   endtask

   // Result checking and the count of quiet cycles for the watchdog.
   always @(posedge clock) begin : result_check
      rsp_type want;
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if (strobe === 1'b1) begin
            if (pending_results.size() == 0) begin
               $display("%0t: result with none expected: expected nothing, actual %p",
                        $time, rsp_item);
               error_count++;
            end else begin
               want = pending_results.pop_front();
               check_field("status", want.status, rsp_item.status);
               check_field("entry_out", want.entry_out, rsp_item.entry_out);
               check_field("ref_count_out", want.ref_count_out, rsp_item.ref_count_out);
               check_field("size_class", want.size_class, rsp_item.size_class);
               check_field("size_valid", want.size_valid, rsp_item.size_valid);
               results_checked++;
               if (!$isunknown(rsp_item.status)) begin
                  status_seen[int'(rsp_item.status)]++;
               end
            end
         end
         if (strobe === 1'b1 || (start && busy === 1'b0)) begin
            quiet_cycles <= 0;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   // Ends a run in which nothing moves for too long.
   initial begin : watchdog
      while (quiet_cycles < QUIET_LIMIT) @(posedge clock);
      $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Stimulus sequence.
   initial begin : stimulus
      stim_row_type directed_rows [TABLE_ROWS];
      key_type      hot_key;
      key_type      key_pool [POOL_SIZE];
      key_type      k;
      int           live [$];
      int           acq_weight;

      hot_key = key_of(129, 128, 0, 0, 32'hA5A5_5A5A);
      directed_rows = '{
         '{acquire_req(key_of(1, 1, 0, 0, 0)), 1'b1, result_of(ST_INSERTED, 0, 1, 0, 1)},
         '{acquire_req(key_of(1, 1, 0, 0, 0)), 1'b1, result_of(ST_FOUND, 0, 2, 0, 1)},
         '{acquire_req(key_of(0, 0, 0, 0, 0)), 1'b1, result_of(ST_INSERTED, 1, 1, 0, 0)},
         '{acquire_req(key_of(256, 3, 15, 7, 32'hFFFF_FFFF)), 1'b1,
           result_of(ST_INSERTED, 2, 1, 8, 1)},
         '{acquire_req(key_of(3, 257, 0, 0, 0)), 1'b1, result_of(ST_INSERTED, 3, 1, 0, 0)},
         '{acquire_req(key_of(4095, 4095, 15, 7, 32'hFFFF_FFFF)), 1'b1,
           result_of(ST_INSERTED, 4, 1, 0, 0)},
         // One key, its one-field and swapped-side variants, and it again.
         '{acquire_req(key_of(5, 2, 1, 1, 32'h1234_5678)), 1'b0, '0},
         '{acquire_req(key_of(2, 5, 1, 1, 32'h1234_5678)), 1'b0, '0},
         '{acquire_req(key_of(5, 2, 1, 2, 32'h1234_5678)), 1'b0, '0},
         '{acquire_req(key_of(5, 2, 2, 1, 32'h1234_5678)), 1'b0, '0},
         '{acquire_req(key_of(5, 2, 1, 1, 32'h1234_5679)), 1'b0, '0},
         '{acquire_req(key_of(5, 2, 1, 1, 32'h1234_5678)), 1'b0, '0},
         // Releases down to free, and past it.
         '{release_req(127), 1'b1, result_of(ST_FREE_REL, 127, 0, 0, 0)},
         '{release_req(0), 1'b1, result_of(ST_STILL_USED, 0, 1, 0, 1)},
         '{release_req(0), 1'b1, result_of(ST_NOW_FREE, 0, 0, 0, 1)},
         '{release_req(0), 1'b1, result_of(ST_FREE_REL, 0, 0, 0, 0)},
         '{release_req(2), 1'b1, result_of(ST_NOW_FREE, 2, 0, 8, 1)},
         '{release_req(3), 1'b1, result_of(ST_NOW_FREE, 3, 0, 0, 0)},
         // Freed entries are reused lowest first; a freed key no longer matches.
         '{acquire_req(hot_key), 1'b1, result_of(ST_INSERTED, 0, 1, 8, 1)},
         '{acquire_req(key_of(256, 3, 15, 7, 32'hFFFF_FFFF)), 1'b1,
           result_of(ST_INSERTED, 2, 1, 8, 1)},
         '{acquire_req(key_of(0, 0, 0, 0, 0)), 1'b1, result_of(ST_FOUND, 1, 2, 0, 0)},
         '{acquire_req(key_of(128, 128, 3, 0, 0)), 1'b0, '0},
         '{release_req(1), 1'b0, '0}
      };

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      for (int n = 0; n < TABLE_ROWS; n++) begin
         apply_request(directed_rows[n].req, directed_rows[n].pinned, directed_rows[n].rsp);
      end

      // Fill every free entry, then show that a new key is refused.
      repeat (DEPTH) begin
         apply_request(acquire_req(fresh_key()), 1'b0, '0);
      end
      apply_request(acquire_req(key_of(16, 1, 9, 5, 32'h0F0F_F0F0)), 1'b1,
                    result_of(ST_FULL, 0, 0, 4, 1));

      // A small pool of keys, mostly of valid size, so acquires hit often.
      for (int p = 0; p < POOL_SIZE; p++) begin
         key_pool[p] = key_of(
            ($urandom_range(9) < 7) ? $urandom_range(1, SIDE_LIMIT) : $urandom_range(4095),
            ($urandom_range(9) < 7) ? $urandom_range(1, SIDE_LIMIT) : $urandom_range(4095),
            $urandom_range(15), $urandom_range(7), $urandom());
      end

      // Random traffic: release-heavy and acquire-heavy stretches alternate so
      // the table drains and fills again.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         idling_on  = !(n >= 250 && n < 400);
         acq_weight = ((n / 100) % 2 == 0) ? 35 : 70;
         if ($urandom_range(99) < acq_weight) begin
            k = ($urandom_range(3) != 0) ? key_pool[$urandom_range(POOL_SIZE - 1)]
                                         : fresh_key();
            apply_request(acquire_req(k), 1'b0, '0);
         end else begin
            live.delete();
            for (int i = 0; i < DEPTH; i++) begin
               if (live_count[i] != 0) begin
                  live.push_back(i);
               end
            end
            if (live.size() > 0 && $urandom_range(99) < 85) begin
               apply_request(release_req(live[$urandom_range(live.size() - 1)]), 1'b0, '0);
            end else begin
               apply_request(release_req($urandom_range(127)), 1'b0, '0);
            end
         end
      end
      start <= 1'b0;

      // Drain, then allow a full table scan for any stray result.
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DEPTH + 8) @(posedge clock);

      $display("Sent %0d requests (directed table, table fill, random); %0d results checked.",
               requests_sent, results_checked);
      $write("Results by status: found %0d, inserted %0d, full %0d, ",
             status_seen[ST_FOUND], status_seen[ST_INSERTED], status_seen[ST_FULL]);
      $display("still used %0d, now free %0d, free release %0d, saturated %0d.",
               status_seen[ST_STILL_USED], status_seen[ST_NOW_FREE],
               status_seen[ST_FREE_REL], status_seen[ST_SATURATED]);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
